// File: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared constants, types and helpers for the text console engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [15:0]       cell_t;

  localparam cell_t      BLANK_RESET  = 16'd10;
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam addr_t      LAST_ADDR    = addr_t'(CELL_COUNT - 1);
  localparam col_t       LAST_COL     = col_t'(COLUMNS - 1);
  localparam row_t       LAST_ROW     = row_t'(ROWS - 1);

  typedef enum logic [2:0] {
    CMD_PUT    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_SCROLL = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_COPY_TAIL,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    cell_t wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    col_t  col;
    row_t  row;
    addr_t offset;
    cell_t data;
  } result_t;

  function automatic addr_t cell_offset(row_t r, col_t c);
    addr_t base;
    base = addr_t'(r) * addr_t'(COLUMNS);
    return base + addr_t'(c);
  endfunction

endpackage

// File: hw/rtl/tcc_cmd_if.sv
// ----------------------------------------------------------------------------
// tcc_cmd_if
// Command channel of the text console engine.
// ----------------------------------------------------------------------------
interface tcc_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] char_code;
  logic [7:0] attribute;
  logic [7:0] column;
  logic [7:0] row;
  logic [7:0] line_count;

  modport source (
    output valid, command, char_code, attribute, column, row, line_count,
    input  ready
  );
  modport sink (
    input  valid, command, char_code, attribute, column, row, line_count,
    output ready
  );
endinterface

// File: hw/rtl/tcc_rsp_if.sv
// ----------------------------------------------------------------------------
// tcc_rsp_if
// Response channel of the text console engine: cursor and read data.
// ----------------------------------------------------------------------------
interface tcc_rsp_if import tcc_pkg::*; ();
  logic  valid;
  logic  ready;
  col_t  cursor_column;
  row_t  cursor_row;
  addr_t cursor_offset;
  cell_t cell_data;

  modport source (
    output valid, cursor_column, cursor_row, cursor_offset, cell_data,
    input  ready
  );
  modport sink (
    input  valid, cursor_column, cursor_row, cursor_offset, cell_data,
    output ready
  );
endinterface

// File: hw/rtl/tcc_screen_mem.sv
// ----------------------------------------------------------------------------
// tcc_screen_mem
// Screen cell memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcc_screen_mem import tcc_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output cell_t    rd_data
);

  cell_t cells [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
    rd_data <= cells[req.raddr];
  end

endmodule

// File: hw/rtl/tcc_ctrl.sv
// ----------------------------------------------------------------------------
// tcc_ctrl
// Command sequencer: cursor state, put/read access and screen sweeps
// (reset fill, clear, scroll copy and blank fill).
// ----------------------------------------------------------------------------
module tcc_ctrl import tcc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tcc_cmd_if.sink  cmd,
  input  cell_t    blank_cell,
  input  logic     out_free,
  input  cell_t    rd_data,
  output mem_req_t mem_req,
  output logic     res_load,
  output result_t  result
);

  state_e state;
  state_e state_next;
  col_t   cur_col;
  row_t   cur_row;
  addr_t  src;
  addr_t  dst;
  logic   rd_pend;
  cell_t  cell_data;

  col_t   col_clamp;
  row_t   row_clamp;
  addr_t  cur_off;
  logic   at_last_col;
  logic   at_last_row;
  logic   is_newline;
  logic   scroll_all;
  row_t   lines_row;

  assign col_clamp   = (cmd.column > 8'(COLUMNS - 1)) ? LAST_COL : cmd.column[COL_W-1:0];
  assign row_clamp   = (cmd.row > 8'(ROWS - 1)) ? LAST_ROW : cmd.row[ROW_W-1:0];
  assign cur_off     = cell_offset(cur_row, cur_col);
  assign at_last_col = (cur_col == LAST_COL);
  assign at_last_row = (cur_row == LAST_ROW);
  assign is_newline  = (cmd.char_code == NEWLINE_CODE);
  assign scroll_all  = (cmd.line_count >= 8'(ROWS));
  assign lines_row   = cmd.line_count[ROW_W-1:0];

  assign cmd.ready = (state == ST_IDLE);

  assign result.col    = cur_col;
  assign result.row    = cur_row;
  assign result.offset = cur_off;
  assign result.data   = cell_data;

  always_comb begin
    state_next    = state;
    mem_req.we    = 1'b0;
    mem_req.waddr = dst;
    mem_req.wdata = rd_data;
    mem_req.raddr = src;
    res_load      = 1'b0;
    case (state)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = BLANK_RESET;
        if (dst == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            CMD_PUT: begin
              if (is_newline) begin
                state_next = at_last_row ? ST_COPY : ST_DONE;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = cur_off;
                mem_req.wdata = {cmd.attribute, cmd.char_code};
                state_next    = (at_last_col && at_last_row) ? ST_COPY : ST_DONE;
              end
            end
            CMD_SCROLL: begin
              if (cmd.line_count == 8'd0) begin
                state_next = ST_DONE;
              end else if (scroll_all) begin
                state_next = ST_FILL;
              end else begin
                state_next = ST_COPY;
              end
            end
            CMD_CLEAR: begin
              state_next = ST_FILL;
            end
            CMD_READ: begin
              mem_req.raddr = cell_offset(row_clamp, col_clamp);
              state_next    = ST_READ;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_COPY: begin
        // write back the cell read last cycle while reading the next one
        mem_req.we = rd_pend;
        if (src == LAST_ADDR) begin
          state_next = ST_COPY_TAIL;
        end
      end
      ST_COPY_TAIL: begin
        mem_req.we = 1'b1;
        state_next = ST_FILL;
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = blank_cell;
        if (dst == LAST_ADDR) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res_load = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      cur_col <= '0;
      cur_row <= '0;
      dst     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ST_COPY);
      case (state)
        ST_INIT: begin
          dst <= dst + 1'b1;
        end
        ST_IDLE: begin
          if (cmd.valid) begin
            cell_data <= '0;
            dst       <= '0;
            case (cmd.command)
              CMD_PUT: begin
                if (is_newline) begin
                  cur_col <= '0;
                  if (at_last_row) begin
                    src <= cell_offset(row_t'(1), '0);
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else if (at_last_col && at_last_row) begin
                  cur_col <= '0;
                  src     <= cell_offset(row_t'(1), '0);
                end else if (at_last_col) begin
                  cur_col <= '0;
                  cur_row <= cur_row + 1'b1;
                end else begin
                  cur_col <= cur_col + 1'b1;
                end
              end
              CMD_SET: begin
                cur_col <= col_clamp;
                cur_row <= row_clamp;
              end
              CMD_SCROLL: begin
                if (scroll_all) begin
                  cur_col <= '0;
                  cur_row <= '0;
                end else begin
                  src <= cell_offset(lines_row, '0);
                  // row saturates at the top
                  cur_row <= (8'(cur_row) >= cmd.line_count) ? cur_row - lines_row : '0;
                end
              end
              CMD_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          cell_data <= rd_data;
        end
        ST_COPY: begin
          src <= src + 1'b1;
          if (rd_pend) begin
            dst <= dst + 1'b1;
          end
        end
        ST_COPY_TAIL: begin
          dst <= dst + 1'b1;
        end
        ST_FILL: begin
          dst <= dst + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// 80x25 text console engine with cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transfer (put, set cursor, scroll, clear,
//   read cell). rsp returns one transfer per command with the cursor after
//   the command, its linear offset, and the read cell (zero otherwise).
//   cfg_we/cfg_wdata write the blank cell used by clear and scroll fill;
//   write it only while no command is in flight.
// Sequence from command transfer to response valid:
//   put, newline, set cursor, other codes: ST_DONE directly; read cell:
//   ST_READ (memory read), then ST_DONE. Scroll of n lines (1..24), or
//   put/newline that scrolls: the ST_COPY/ST_COPY_TAIL/ST_FILL sweep that
//   copies and blank-fills all 2000 cells. Clear, or scroll of 25 or more:
//   ST_FILL sweep only. One command at a time; the next command is taken
//   while a finished response still waits.
// Reset: the cursor homes and a pass fills the screen with the reset
//   blank cell; cmd.ready stays low until it ends.
// Stall: while rsp is not taken, the next command completes and then waits.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll import tcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tcc_cmd_if.sink   cmd,
  tcc_rsp_if.source rsp,
  input  logic      cfg_we,
  input  cell_t     cfg_wdata
);

  cell_t    blank_cell;
  logic     out_valid;
  result_t  out_data;
  logic     out_free;
  mem_req_t mem_req;
  cell_t    rd_data;
  logic     res_load;
  result_t  result;

  assign out_free = !out_valid || rsp.ready;

  tcc_screen_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  tcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .blank_cell (blank_cell),
    .out_free   (out_free),
    .rd_data    (rd_data),
    .mem_req    (mem_req),
    .res_load   (res_load),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_cell <= BLANK_RESET;
    end else if (cfg_we) begin
      blank_cell <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_load) begin
      out_data <= result;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.cursor_column = out_data.col;
  assign rsp.cursor_row    = out_data.row;
  assign rsp.cursor_offset = out_data.offset;
  assign rsp.cell_data     = out_data.data;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console engine. A directed table covers
// the screen corners, clamping, wraps, scroll edges and clear. Random command
// streams follow under three blank-cell settings and three idle/stall mixes.
// Every response is checked against its typed table row or a cycle-free screen predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import tcc_pkg::*;

  localparam logic [2:0]  CMD_SPARE_LO   = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 2100;
  localparam int unsigned PHASE_ITEMS    = 540;

  typedef struct {
    logic [2:0] command;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] line_count;
  } console_cmd_t;

  typedef struct {
    console_cmd_t cmd;
    bit           typed;
    result_t      want;
  } console_case_t;

  logic  clk;
  logic  rst;
  logic  cfg_we;
  cell_t cfg_wdata;

  tcc_cmd_if cmd_ch ();
  tcc_rsp_if rsp_ch ();

  text_console_cursor_scroll dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // screen image and cursor as the block should hold them
  cell_t       screen_img [CELL_COUNT];
  int unsigned cur_c;
  int unsigned cur_r;
  cell_t       blank_now;

  result_t       cursor_due [$];
  console_case_t directed_cases [$];
  int unsigned   mismatch_count;
  int unsigned   quiet_cycles;
  int unsigned   tx_idle_pct;
  int unsigned   rx_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void wipe_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_img[i] = blank_now;
    cur_c = 0;
    cur_r = 0;
  endfunction

  function automatic void shift_up(int unsigned n);
    int unsigned src;
    if (n == 0) return;
    if (n >= ROWS) begin
      wipe_screen();
      return;
    end
    for (int i = 0; i < CELL_COUNT; i++) begin
      src = i + n * COLUMNS;
      screen_img[i] = (src < CELL_COUNT) ? screen_img[src] : blank_now;
    end
    cur_r = (cur_r >= n) ? cur_r - n : 0;
  endfunction

  function automatic void line_feed();
    if (cur_r >= ROWS - 1) begin
      shift_up(1);
      cur_r = ROWS - 1;
    end else begin
      cur_r++;
    end
    cur_c = 0;
  endfunction

  function automatic void step_cursor();
    if (cur_c >= COLUMNS - 1 && cur_r >= ROWS - 1) begin
      shift_up(1);
      cur_c = 0;
      cur_r = ROWS - 1;
    end else if (cur_c >= COLUMNS - 1) begin
      cur_c = 0;
      cur_r++;
    end else begin
      cur_c++;
    end
  endfunction

  function automatic int unsigned clamp_col(logic [7:0] v);
    return (v > COLUMNS - 1) ? COLUMNS - 1 : int'(v);
  endfunction

  function automatic int unsigned clamp_row(logic [7:0] v);
    return (v > ROWS - 1) ? ROWS - 1 : int'(v);
  endfunction

  // applies one command to the screen image and returns the cursor report
  function automatic result_t console_step(console_cmd_t c);
    result_t     r;
    int unsigned data;
    data = 0;
    case (c.command)
      CMD_PUT: begin
        if (c.char_code == NEWLINE_CODE) begin
          line_feed();
        end else begin
          screen_img[cur_r * COLUMNS + cur_c] = {c.attribute, c.char_code};
          step_cursor();
        end
      end
      CMD_SET: begin
        cur_c = clamp_col(c.column);
        cur_r = clamp_row(c.row);
      end
      CMD_SCROLL: shift_up(c.line_count);
      CMD_CLEAR:  wipe_screen();
      CMD_READ:   data = screen_img[clamp_row(c.row) * COLUMNS + clamp_col(c.column)];
      default: ;
    endcase
    r.col    = col_t'(cur_c);
    r.row    = row_t'(cur_r);
    r.offset = addr_t'(cur_r * COLUMNS + cur_c);
    r.data   = cell_t'(data);
    return r;
  endfunction

  function automatic console_cmd_t random_command();
    console_cmd_t c;
    int unsigned  pick;
    c.char_code = ($urandom_range(9) == 0) ? NEWLINE_CODE : 8'($urandom);
    c.attribute = 8'($urandom);
    c.column    = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(COLUMNS - 1));
    c.row       = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(ROWS - 1));
    c.line_count = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 52) begin
      c.command = CMD_PUT;
    end else if (pick < 66) begin
      c.command = CMD_SET;
    end else if (pick < 70) begin
      // sweeps are slow, so mostly short scrolls
      c.command = CMD_SCROLL;
      if ($urandom_range(9) != 0) c.line_count = 8'($urandom_range(3));
    end else if (pick < 72) begin
      c.command = CMD_CLEAR;
    end else if (pick < 93) begin
      c.command = CMD_READ;
    end else begin
      c.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    return c;
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic issue_command(console_cmd_t c, bit typed, result_t want);
    result_t got;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      = 1'b1;
    cmd_ch.command    = c.command;
    cmd_ch.char_code  = c.char_code;
    cmd_ch.attribute  = c.attribute;
    cmd_ch.column     = c.column;
    cmd_ch.row        = c.row;
    cmd_ch.line_count = c.line_count;
    do @(posedge clk); while (!cmd_ch.ready);
    got = console_step(c);
    cursor_due.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_ch.valid = 1'b0;
    while (cursor_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_blank(cell_t v);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    blank_now = v;
  endtask

  task automatic add_row(logic [2:0] cm, logic [7:0] ch, logic [7:0] at,
                         logic [7:0] co, logic [7:0] ro, logic [7:0] ln);
    directed_cases.push_back('{'{cm, ch, at, co, ro, ln}, 1'b0, '0});
  endtask

  task automatic add_typed(logic [2:0] cm, logic [7:0] ch, logic [7:0] at,
                           logic [7:0] co, logic [7:0] ro, logic [7:0] ln,
                           col_t ec, row_t er, addr_t eo, cell_t ed);
    result_t w;
    w.col    = ec;
    w.row    = er;
    w.offset = eo;
    w.data   = ed;
    directed_cases.push_back('{'{cm, ch, at, co, ro, ln}, 1'b1, w});
  endtask

  task automatic load_directed();
    add_typed(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, BLANK_RESET);
    add_typed(CMD_READ, 0, 0, 8'hFF, 8'hFF, 0, 0, 0, 0, BLANK_RESET);
    add_typed(CMD_SET, 0, 0, 8'hFF, 8'hFF, 0, LAST_COL, LAST_ROW, LAST_ADDR, 0);
    // put at bottom right scrolls and parks the cursor on the last row
    add_typed(CMD_PUT, 8'h41, 8'hFF, 0, 0, 0, 0, LAST_ROW,
              addr_t'((ROWS - 1) * COLUMNS), 0);
    add_row(CMD_READ, 0, 0, 79, 23, 0);
    add_row(CMD_READ, 0, 0, 0, 24, 0);
    add_typed(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_PUT, 8'h00, 8'h00, 0, 0, 0);
    add_row(CMD_PUT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_row(CMD_PUT, NEWLINE_CODE, 8'h5A, 0, 0, 0);
    add_row(CMD_SET, 0, 0, 3, 24, 0);
    add_row(CMD_PUT, NEWLINE_CODE, 8'h00, 0, 0, 0);
    add_row(CMD_SET, 0, 0, 79, 5, 0);
    add_row(CMD_PUT, 8'h78, 8'h1E, 0, 0, 0);
    add_row(CMD_SCROLL, 0, 0, 0, 0, 0);
    add_row(CMD_SCROLL, 0, 0, 0, 0, 1);
    add_row(CMD_SET, 0, 0, 10, 20, 0);
    add_row(CMD_SCROLL, 0, 0, 0, 0, 24);
    add_row(CMD_READ, 0, 0, 0, 0, 0);
    add_typed(CMD_SCROLL, 0, 0, 0, 0, 25, 0, 0, 0, 0);
    add_row(CMD_PUT, 8'h61, 8'h07, 0, 0, 0);
    add_typed(CMD_SCROLL, 0, 0, 0, 0, 8'hFF, 0, 0, 0, 0);
    add_row(CMD_PUT, 8'h62, 8'h70, 0, 0, 0);
    add_typed(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(CMD_SPARE_LO, 0, 0, 0, 0, 0);
    add_row(CMD_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_typed(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, BLANK_RESET);
  endtask

  task automatic run_phase(int unsigned items, int unsigned tx_pct, int unsigned rx_pct);
    console_cmd_t c;
    int unsigned  sent;
    int unsigned  burst;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(39) == 0) begin
        // a run of 20 to 100 puts, long enough at the top end to wrap a line
        burst = $urandom_range(20, 100);
        repeat (burst) begin
          c = random_command();
          c.command = CMD_PUT;
          issue_command(c, 1'b0, '0);
          sent++;
        end
      end else begin
        c = random_command();
        issue_command(c, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(63) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : response_check
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (cursor_due.size() == 0) begin
        $display("%0t: unexpected transfer col=%0d row=%0d off=%0d data=%h", $time,
                 rsp_ch.cursor_column, rsp_ch.cursor_row, rsp_ch.cursor_offset,
                 rsp_ch.cell_data);
        mismatch_count++;
      end else begin
        want = cursor_due.pop_front();
        if (rsp_ch.cursor_column !== want.col) begin
          $display("%0t: cursor_column expected %0d got %0d", $time, want.col,
                   rsp_ch.cursor_column);
          mismatch_count++;
        end
        if (rsp_ch.cursor_row !== want.row) begin
          $display("%0t: cursor_row expected %0d got %0d", $time, want.row,
                   rsp_ch.cursor_row);
          mismatch_count++;
        end
        if (rsp_ch.cursor_offset !== want.offset) begin
          $display("%0t: cursor_offset expected %0d got %0d", $time, want.offset,
                   rsp_ch.cursor_offset);
          mismatch_count++;
        end
        if (rsp_ch.cell_data !== want.data) begin
          $display("%0t: cell_data expected %h got %h", $time, want.data,
                   rsp_ch.cell_data);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("** text_console_cursor_scroll: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_PUT;
    cmd_ch.char_code  = '0;
    cmd_ch.attribute  = '0;
    cmd_ch.column     = '0;
    cmd_ch.row        = '0;
    cmd_ch.line_count = '0;
    mismatch_count    = 0;
    quiet_cycles      = 0;
    tx_idle_pct       = 23;
    rx_stall_pct      = 46;
    blank_now         = BLANK_RESET;
    wipe_screen();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // the block sweeps the screen after reset before it takes commands
    while (!cmd_ch.ready) @(negedge clk);

    load_directed();
    foreach (directed_cases[i])
      issue_command(directed_cases[i].cmd, directed_cases[i].typed, directed_cases[i].want);
    drain_results();

    write_blank(16'hFFFF);
    run_phase(PHASE_ITEMS, 23, 46);
    write_blank(16'h0000);
    run_phase(PHASE_ITEMS, 46, 23);
    write_blank(cell_t'($urandom));
    run_phase(PHASE_ITEMS, 0, 0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (cursor_due.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, cursor_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** text_console_cursor_scroll: PASSED **");
    end else begin
      $display("** text_console_cursor_scroll: FAILED **");
    end
    $finish;
  end

endmodule

// File: text_console_cursor_scroll.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_cmd_if.sv
hw/rtl/tcc_rsp_if.sv
hw/rtl/tcc_screen_mem.sv
hw/rtl/tcc_ctrl.sv
hw/rtl/text_console_cursor_scroll.sv
dv/tb_top.sv
